// ===== sv/assert_macros.svh =====
// Assertion macros used by object_hue_class_sorter.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, muted while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/ohcs_pkg.sv =====
// Package with the constants and register indexes of the hue class sorter.
package ohcs_pkg;

    // Default sizing
    localparam int CLASS_COUNT_DEF    = 5;
    localparam int POSITION_WIDTH_DEF = 16;
    localparam int COUNTER_WIDTH_DEF  = 24;

    // Fixed field widths
    localparam int FRAME_WIDTH  = 16;
    localparam int HUE_WIDTH    = 8;
    localparam int CLASS_OUT_W  = 3;
    localparam int CFG_IDX_W    = 3;

    // Hue scale
    localparam int HUE_MAX      = 255;
    localparam int HUE_HALF     = 128;

    // Red / orange split: 100*hue + 16*sat < 3600 means red
    localparam int MIX_W        = 15;
    localparam int RED_HUE_K    = 100;
    localparam int RED_SAT_K    = 16;
    localparam int RED_LIMIT    = 3600;
    localparam int CLASS_ORANGE = 1;
    localparam int CLASS_RED    = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLASS_HUES  = 3'd0,
        REG_EJECT_MASK  = 3'd1,
        REG_AREA_LEFT   = 3'd2,
        REG_AREA_RIGHT  = 3'd3,
        REG_AREA_BOTTOM = 3'd4,
        REG_AREA_TOP    = 3'd5
    } t_cfg_reg;

endpackage

// ===== sv/object_hue_class_sorter.sv =====
// Top level: nearest-hue object classifier with area gate and saturating counters.
//
//  channel | handshake                    | payload
//  --------+------------------------------+-----------------------------------------------
//  in      | i_in_valid / o_in_stall      | i_frame_start i_pos_x i_pos_y i_hue i_saturation
//  out     | o_out_valid / i_out_stall    | o_valid_res o_color_class o_eject o_class_count
//          |                              | o_total_classified o_frame_classified
//  cfg     | i_cfg_valid / o_cfg_ready    | i_cfg_index i_cfg_data
//
//  One beat per cycle sustained while i_out_stall is low; path: input register, then result register.
//  The area compare, hue search over the classes, red/orange split and counter update
//  all sit between the input register and the result register.
//  Reset (synchronous, active low) clears counters, valids and config to defaults.
//  A stalled result holds; the input register still fills behind it, then the input
//  side stalls until the result is taken. Counters move only when a beat enters the
//  result register. o_cfg_ready is always high.

`include "assert_macros.svh"

module object_hue_class_sorter #(
    parameter int CLASS_COUNT    = ohcs_pkg::CLASS_COUNT_DEF,
    parameter int POSITION_WIDTH = ohcs_pkg::POSITION_WIDTH_DEF,
    parameter int COUNTER_WIDTH  = ohcs_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input beats
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_frame_start,
    input  logic signed [POSITION_WIDTH-1:0]       i_pos_x,
    input  logic signed [POSITION_WIDTH-1:0]       i_pos_y,
    input  logic [ohcs_pkg::HUE_WIDTH-1:0]         i_hue,
    input  logic [ohcs_pkg::HUE_WIDTH-1:0]         i_saturation,
    // result beats
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_valid_res,
    output logic [ohcs_pkg::CLASS_OUT_W-1:0]       o_color_class,
    output logic                                   o_eject,
    output logic [COUNTER_WIDTH-1:0]               o_class_count,
    output logic [COUNTER_WIDTH-1:0]               o_total_classified,
    output logic [ohcs_pkg::FRAME_WIDTH-1:0]       o_frame_classified,
    // config writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ohcs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [((8*CLASS_COUNT > POSITION_WIDTH) ?
                   8*CLASS_COUNT : POSITION_WIDTH)-1:0] i_cfg_data
);
    import ohcs_pkg::*;

    localparam int CLS_W  = $clog2(CLASS_COUNT);
    localparam int HUES_W = HUE_WIDTH * CLASS_COUNT;
    localparam logic [CLS_W-1:0] CLS_ORANGE = CLS_W'(CLASS_ORANGE);
    localparam logic [CLS_W-1:0] CLS_RED    = CLS_W'(CLASS_RED);
    localparam logic signed [POSITION_WIDTH-1:0] POS_MIN = {1'b1, {(POSITION_WIDTH-1){1'b0}}};
    localparam logic signed [POSITION_WIDTH-1:0] POS_MAX = {1'b0, {(POSITION_WIDTH-1){1'b1}}};

    // ---------------- configuration registers ----------------
    logic [HUES_W-1:0]                r_class_hues;
    logic [CLASS_COUNT-1:0]           r_eject_mask;
    logic signed [POSITION_WIDTH-1:0] r_area_left, r_area_right, r_area_bottom, r_area_top;
    logic [HUES_W-1:0]                w_hue_rst;
    logic                             w_cfg_wr;

    // default hue of class g is g*255/CLASS_COUNT
    for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_hue_rst
        localparam int HUE_RST = (g * HUE_MAX) / CLASS_COUNT;
        assign w_hue_rst[HUE_WIDTH*g +: HUE_WIDTH] = HUE_WIDTH'(HUE_RST);
    end

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_hues  <= w_hue_rst;
            r_eject_mask  <= '0;
            r_area_left   <= POS_MIN;
            r_area_right  <= POS_MAX;
            r_area_bottom <= POS_MIN;
            r_area_top    <= POS_MAX;
        end else if (w_cfg_wr) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_CLASS_HUES:  r_class_hues  <= i_cfg_data[HUES_W-1:0];
                REG_EJECT_MASK:  r_eject_mask  <= i_cfg_data[CLASS_COUNT-1:0];
                REG_AREA_LEFT:   r_area_left   <= i_cfg_data[POSITION_WIDTH-1:0];
                REG_AREA_RIGHT:  r_area_right  <= i_cfg_data[POSITION_WIDTH-1:0];
                REG_AREA_BOTTOM: r_area_bottom <= i_cfg_data[POSITION_WIDTH-1:0];
                REG_AREA_TOP:    r_area_top    <= i_cfg_data[POSITION_WIDTH-1:0];
                default: ;   // unknown index: write dropped
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    logic r_s1_valid, r_out_valid;
    logic w_out_adv;   // result register can take a beat
    logic w_fire;      // stage-1 beat moves into the result register

    assign w_out_adv  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_s1_valid && w_out_adv;
    assign o_in_stall = r_s1_valid && !w_out_adv;
    assign o_out_valid = r_out_valid;

    // ---------------- input register ----------------
    logic                             r_frame_start;
    logic signed [POSITION_WIDTH-1:0] r_pos_x, r_pos_y;
    logic [HUE_WIDTH-1:0]             r_hue, r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_frame_start <= i_frame_start;
            r_pos_x       <= i_pos_x;
            r_pos_y       <= i_pos_y;
            r_hue         <= i_hue;
            r_sat         <= i_saturation;
        end
    end

    // ---------------- classification ----------------
    logic                 w_in_area;
    logic [HUE_WIDTH-1:0] w_dist [CLASS_COUNT];
    logic [CLS_W-1:0]     w_near;
    logic [HUE_WIDTH-1:0] w_near_d;
    logic [MIX_W-1:0]     w_mix;
    logic [CLS_W-1:0]     w_cls;

    assign w_in_area = (r_pos_x >= r_area_left)   && (r_pos_x <= r_area_right) &&
                       (r_pos_y >= r_area_bottom) && (r_pos_y <= r_area_top);

    // circular distance per class, folded onto 0..128
    for (genvar g = 0; g < CLASS_COUNT; g++) begin : g_dist
        logic [HUE_WIDTH-1:0] w_diff;
        assign w_diff    = r_hue - r_class_hues[HUE_WIDTH*g +: HUE_WIDTH];
        assign w_dist[g] = (w_diff > HUE_WIDTH'(HUE_HALF)) ? (~w_diff + 1'b1) : w_diff;
    end

    // lowest index wins ties (strict less-than)
    always_comb begin
        w_near   = '0;
        w_near_d = w_dist[0];
        for (int i = 1; i < CLASS_COUNT; i++) begin
            if (w_dist[i] < w_near_d) begin
                w_near   = CLS_W'(i);
                w_near_d = w_dist[i];
            end
        end
    end

    assign w_mix = MIX_W'(r_hue) * MIX_W'(RED_HUE_K) + MIX_W'(r_sat) * MIX_W'(RED_SAT_K);

    always_comb begin
        w_cls = w_near;
        if (w_near == CLS_ORANGE || w_near == CLS_RED) begin
            w_cls = (w_mix < MIX_W'(RED_LIMIT)) ? CLS_RED : CLS_ORANGE;
        end
    end

    // ---------------- counters ----------------
    logic [COUNTER_WIDTH-1:0] r_cls_cnt [CLASS_COUNT];
    logic [COUNTER_WIDTH-1:0] r_total;
    logic [FRAME_WIDTH-1:0]   r_frame;
    logic [COUNTER_WIDTH-1:0] n_cls_cnt, n_total;
    logic [FRAME_WIDTH-1:0]   w_frame_base, n_frame;
    logic [COUNTER_WIDTH-1:0] w_cls_cur;

    assign w_cls_cur    = r_cls_cnt[w_cls];
    assign n_cls_cnt    = (&w_cls_cur) ? w_cls_cur : w_cls_cur + 1'b1;
    assign w_frame_base = r_frame_start ? '0 : r_frame;

    always_comb begin
        n_total = r_total;
        n_frame = w_frame_base;
        if (w_in_area) begin
            n_total = (&r_total) ? r_total : r_total + 1'b1;
            n_frame = (&w_frame_base) ? w_frame_base : w_frame_base + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CLASS_COUNT; i++) begin
                r_cls_cnt[i] <= '0;
            end
            r_total <= '0;
            r_frame <= '0;
        end else if (w_fire) begin
            r_total <= n_total;
            r_frame <= n_frame;
            if (w_in_area) begin
                r_cls_cnt[w_cls] <= n_cls_cnt;
            end
        end
    end

    // ---------------- result register ----------------
    logic                     r_valid_res, r_eject;
    logic [CLS_W-1:0]         r_color_class;
    logic [COUNTER_WIDTH-1:0] r_class_count, r_total_out;
    logic [FRAME_WIDTH-1:0]   r_frame_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_valid_res   <= w_in_area;
            r_color_class <= w_in_area ? w_cls : '0;
            r_eject       <= w_in_area && r_eject_mask[w_cls];
            r_class_count <= w_in_area ? n_cls_cnt : '0;
            r_total_out   <= n_total;
            r_frame_out   <= n_frame;
        end
    end

    assign o_valid_res        = r_valid_res;
    assign o_color_class      = CLASS_OUT_W'(r_color_class);
    assign o_eject            = r_eject;
    assign o_class_count      = r_class_count;
    assign o_total_classified = r_total_out;
    assign o_frame_classified = r_frame_out;

    // ---------------- assertions ----------------
    `ASSERT_CLK(a_total_monotonic, $past(i_rst_n) |-> r_total >= $past(r_total), "total counter went down")
    `ASSERT_CLK(a_invalid_zero, (r_out_valid && !r_valid_res) |-> (r_color_class == '0 && !r_eject && r_class_count == '0), "invalid result carries class data")
    `ASSERT_CLK(a_stall_holds_counts, (r_out_valid && i_out_stall) |=> $stable(r_total) && $stable(r_frame), "counters moved while result stalled")
    `ASSERT_CLK_ALWAYS(a_stall_needs_item, o_in_stall |-> r_s1_valid, "input stalled with empty input register")

endmodule
